[src/glc_pkg.sv]
// glc_pkg: shared constants, types and codes for the graph local complementation unit.
// No dependencies. Used by the channel interfaces, controller, datapath and top level.
package glc_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int ROW_W        = 32;
	localparam int VCNT_W       = 6;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int ACT_W        = 2;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam int REG_IDX_W    = PADDR_W - 2;

	localparam logic [VCNT_W-1:0]    VCOUNT_RESET     = VCNT_W'(32);
	localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = REG_IDX_W'(0);

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PIVOT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WRITE,
		ST_PIV_RD,
		ST_PIV_MASK,
		ST_SWEEP,
		ST_SW_LAST,
		ST_READ,
		ST_RESP
	} glc_state_t;

	typedef struct packed {
		logic              load_item;
		logic              wr_item;
		logic              rd_item;
		logic              rd_sweep;
		logic              wr_sweep;
		logic              cap_mask;
		logic              load_out;
		logic [VIDX_W-1:0] rd_idx;
		logic [VIDX_W-1:0] wr_idx;
	} glc_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             bad;
	} glc_stat_t;

endpackage

[src/glc_if.sv]
// glc_in_if / glc_out_if: valid/ready channels for action items and result items.
// Depends on glc_pkg.
interface glc_in_if;
	import glc_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [VIDX_W-1:0] vertex;
	logic [ROW_W-1:0]  row_bits;
	logic              color_in;

	modport source (output valid, action, vertex, row_bits, color_in, input ready);
	modport sink   (input valid, action, vertex, row_bits, color_in, output ready);
endinterface

interface glc_out_if;
	import glc_pkg::*;

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_out;
	logic             color_out;
	logic             bad_vertex;

	modport source (output valid, row_out, color_out, bad_vertex, input ready);
	modport sink   (input valid, row_out, color_out, bad_vertex, output ready);
endinterface

[src/graph_local_complementation_unit.sv]
// Graph local complementation unit: top level with the APB register and channel wiring.
// Depends on glc_pkg, glc_if, glc_ctrl and glc_dp.
//
// Holds a 32-vertex graph as 32 adjacency rows of 32 bits in a row memory with one read and
// one write port, plus one color bit per vertex. One item is taken at a time and gives one
// result. A read goes through decode, memory read and result load; a write through decode,
// row write, memory read and result load; a pivot at a bad vertex like a read. A valid pivot
// reads the pivot row, captures the neighbor mask and sweeps over all 32 rows, each cycle
// reading one row and writing back the previous one if it is a neighbor. The input is ready
// again in the cycle after the result is loaded. A new item is accepted while the previous
// result still waits in the output register. Rows read as zero after reset through per-row
// valid bits; no clearing pass is run. vertex_count sits at byte address 0; the user must
// write it only while no item is in work; the block has no check for this.
module graph_local_complementation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	glc_in_if.sink                        in_ch,
	glc_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [glc_pkg::PADDR_W-1:0]   paddr,
	input  logic [glc_pkg::PDATA_W-1:0]   pwdata,
	output logic [glc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import glc_pkg::*;

	logic [VCNT_W-1:0] vertex_count_q;
	logic              reg_hit;
	glc_cmd_t          cmd;
	glc_stat_t         stat;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);
	assign prdata  = reg_hit ? PDATA_W'(vertex_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			vertex_count_q <= pwdata[VCNT_W-1:0];
		end
	end

	glc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	glc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.vertex_count (vertex_count_q),
		.action       (in_ch.action),
		.vertex       (in_ch.vertex),
		.row_bits     (in_ch.row_bits),
		.color_in     (in_ch.color_in),
		.row_out      (out_ch.row_out),
		.color_out    (out_ch.color_out),
		.bad_vertex   (out_ch.bad_vertex)
	);

endmodule

[src/glc_ctrl.sv]
// glc_ctrl: sequencer for write, read and pivot actions, including the row sweep counter
// and the result slot valid flag. Depends on glc_pkg.
module glc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  glc_pkg::glc_stat_t   stat,
	output glc_pkg::glc_cmd_t    cmd
);
	import glc_pkg::*;

	glc_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_m1;
	logic             out_valid_q;

	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_PIV_MASK)
				cnt_q <= '0;
			else if (state_q == ST_SWEEP)
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_DECODE;
			ST_DECODE: begin
				case (stat.action)
					ACT_WRITE: state_nxt = ST_WRITE;
					ACT_PIVOT: state_nxt = stat.bad ? ST_READ : ST_PIV_RD;
					default:   state_nxt = ST_READ;
				endcase
			end
			ST_WRITE:    state_nxt = ST_READ;
			ST_PIV_RD:   state_nxt = ST_PIV_MASK;
			ST_PIV_MASK: state_nxt = ST_SWEEP;
			ST_SWEEP:    if (cnt_q == CNT_W'(MAX_VERTICES - 1)) state_nxt = ST_SW_LAST;
			ST_SW_LAST:  state_nxt = ST_READ;
			ST_READ:     state_nxt = ST_RESP;
			ST_RESP:     if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_idx = cnt_q[VIDX_W-1:0];
		cmd.wr_idx = cnt_m1[VIDX_W-1:0];
		case (state_q)
			ST_IDLE:     cmd.load_item = in_valid;
			ST_WRITE:    cmd.wr_item   = 1'b1;
			ST_PIV_RD:   cmd.rd_item   = 1'b1;
			ST_PIV_MASK: cmd.cap_mask  = 1'b1;
			ST_SWEEP: begin
				cmd.rd_sweep = 1'b1;
				cmd.wr_sweep = (cnt_q != '0);
			end
			ST_SW_LAST:  cmd.wr_sweep  = 1'b1;
			ST_READ:     cmd.rd_item   = 1'b1;
			ST_RESP:     cmd.load_out  = !out_valid_q || out_ready;
			default:     cmd.load_item = 1'b0;
		endcase
	end

	a_load_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an unsent result");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in work");

	a_sweep_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_sweep && cmd.wr_sweep) |-> (cmd.rd_idx != cmd.wr_idx))
		else $error("sweep reads and writes the same row");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES))
		else $error("sweep counter overran the row count");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result dropped before transfer");

endmodule

[src/glc_dp.sv]
// glc_dp: adjacency row memory with per-row valid bits, color register, item and neighbor
// registers, and the result register. Depends on glc_pkg.
module glc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  glc_pkg::glc_cmd_t           cmd,
	output glc_pkg::glc_stat_t          stat,
	input  logic [glc_pkg::VCNT_W-1:0]  vertex_count,
	input  logic [glc_pkg::ACT_W-1:0]   action,
	input  logic [glc_pkg::VIDX_W-1:0]  vertex,
	input  logic [glc_pkg::ROW_W-1:0]   row_bits,
	input  logic                        color_in,
	output logic [glc_pkg::ROW_W-1:0]   row_out,
	output logic                        color_out,
	output logic                        bad_vertex
);
	import glc_pkg::*;

	logic [ACT_W-1:0]        action_q;
	logic [VIDX_W-1:0]       vertex_q;
	logic [ROW_W-1:0]        row_q;
	logic                    color_q;

	logic [ROW_W-1:0]        mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] valid_q;
	logic [ROW_W-1:0]        rd_row_s1;
	logic                    rd_vld_s1;
	logic [ROW_W-1:0]        rdata;

	logic [ROW_W-1:0]        n_q;
	logic [ROW_W-1:0]        colors_q;
	logic [ROW_W-1:0]        row_out_q;
	logic                    color_out_q;
	logic                    bad_q;

	logic [VCNT_W-1:0]       count_eff;
	logic [ROW_W-1:0]        active_mask;
	logic                    bad;
	logic                    re;
	logic [VIDX_W-1:0]       raddr;
	logic                    we;
	logic [VIDX_W-1:0]       waddr;
	logic [ROW_W-1:0]        wdata;

	assign count_eff = (vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
		: vertex_count;

	always_comb begin
		for (int j = 0; j < ROW_W; j++)
			active_mask[j] = (VCNT_W'(j) < count_eff);
	end

	assign bad         = (VCNT_W'(vertex_q) >= count_eff);
	assign stat.action = action_q;
	assign stat.bad    = bad;

	assign re    = cmd.rd_item | cmd.rd_sweep;
	assign raddr = cmd.rd_sweep ? cmd.rd_idx : vertex_q;
	assign rdata = rd_vld_s1 ? rd_row_s1 : '0;

	always_comb begin
		we    = 1'b0;
		waddr = vertex_q;
		wdata = row_q;
		if (cmd.wr_item) begin
			we = 1'b1;
		end else if (cmd.wr_sweep && n_q[cmd.wr_idx]) begin
			we    = 1'b1;
			waddr = cmd.wr_idx;
			wdata = rdata ^ (n_q & ~(ROW_W'(1) << cmd.wr_idx));
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_row_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			colors_q  <= '0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re)
				rd_vld_s1 <= valid_q[raddr];
			if (cmd.wr_item)
				colors_q[vertex_q] <= color_q;
			else if (cmd.cap_mask)
				colors_q <= colors_q ^ (rdata & active_mask);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= action;
			vertex_q <= vertex;
			row_q    <= row_bits;
			color_q  <= color_in;
		end
		if (cmd.cap_mask)
			n_q <= rdata & active_mask;
		if (cmd.load_out) begin
			row_out_q   <= rdata;
			color_out_q <= colors_q[vertex_q];
			bad_q       <= bad;
		end
	end

	assign row_out    = row_out_q;
	assign color_out  = color_out_q;
	assign bad_vertex = bad_q;

endmodule

[tb/graph_local_complementation_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for graph_local_complementation_unit: directed and random writes, reads and pivots
// checked against an in-bench graph predictor. Depends on glc_pkg, glc_if and the RTL.
module graph_local_complementation_unit_tb;
	import glc_pkg::*;

	localparam logic [ACT_W-1:0] ACT_READ_ALT = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 1600;
	localparam int NUM_PHASES   = 12;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [VIDX_W-1:0] vertex;
		logic [ROW_W-1:0]  row_bits;
		logic              color_in;
	} glc_action_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             color;
		logic             bad;
	} glc_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	glc_in_if  in_ch ();
	glc_out_if out_ch ();

	graph_local_complementation_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted graph state
	logic [ROW_W-1:0]  graph_rows [MAX_VERTICES];
	logic [ROW_W-1:0]  vertex_colors;
	logic [VCNT_W-1:0] vertex_limit;

	glc_action_t pending_actions [$];
	glc_result_t predicted_results [$];

	logic              src_idle_on;
	logic              rx_idle_on;
	logic [1:0]        src_gap;
	logic [1:0]        rx_stall;
	logic              hold_request;
	int                hold_left;
	int                mismatches;
	logic [VCNT_W-1:0] phase_counts [NUM_PHASES];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int effective_count();
		return (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
	endfunction

	function automatic glc_result_t apply_action(glc_action_t a);
		logic [ROW_W-1:0] nbrs;
		logic [ROW_W-1:0] in_use;
		int               eff;
		glc_result_t      r;
		eff = effective_count();
		in_use = (eff >= ROW_W) ? '1 : ((ROW_W'(1) << eff) - ROW_W'(1));
		r.bad = (int'(a.vertex) >= eff);
		if (a.action == ACT_WRITE) begin
			graph_rows[a.vertex] = a.row_bits;
			vertex_colors[a.vertex] = a.color_in;
		end else if (a.action == ACT_PIVOT && !r.bad) begin
			nbrs = graph_rows[a.vertex] & in_use;
			for (int i = 0; i < MAX_VERTICES; i++)
				if (nbrs[i])
					graph_rows[i] = graph_rows[i] ^ (nbrs & ~(ROW_W'(1) << i));
			vertex_colors = vertex_colors ^ nbrs;
		end
		r.row = graph_rows[a.vertex];
		r.color = vertex_colors[a.vertex];
		return r;
	endfunction

	function automatic glc_action_t random_action(int eff);
		glc_action_t a;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			a.action = ACT_WRITE;
		else if (pick < 70)
			a.action = ACT_PIVOT;
		else if (pick < 95)
			a.action = ACT_READ;
		else
			a.action = ACT_READ_ALT;
		if (eff > 0 && $urandom_range(0, 9) < 8)
			a.vertex = VIDX_W'($urandom_range(0, eff - 1));
		else
			a.vertex = VIDX_W'($urandom_range(0, MAX_VERTICES - 1));
		case ($urandom_range(0, 7))
			0: a.row_bits = '0;
			1: a.row_bits = '1;
			2: a.row_bits = $urandom() & $urandom() & $urandom();
			default: a.row_bits = $urandom();
		endcase
		a.color_in = 1'($urandom_range(0, 1));
		return a;
	endfunction

	task automatic queue_action(logic [ACT_W-1:0] act, int v, logic [ROW_W-1:0] row, logic col);
		pending_actions = {pending_actions, glc_action_t'{act, VIDX_W'(v), row, col}};
	endtask

	task automatic wait_idle();
		while (pending_actions.size() != 0 || in_ch.valid || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_vertex_count(logic [VCNT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_VERTEX_COUNT, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		vertex_limit = value;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		glc_action_t next_a;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= '0;
			in_ch.vertex <= '0;
			in_ch.row_bits <= '0;
			in_ch.color_in <= 1'b0;
			src_gap <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predicted_results = {predicted_results,
					apply_action(glc_action_t'{in_ch.action, in_ch.vertex,
					in_ch.row_bits, in_ch.color_in})};
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap != 0) begin
					in_ch.valid <= 1'b0;
					src_gap <= src_gap - 2'd1;
				end else if (pending_actions.size() != 0) begin
					next_a = pending_actions.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.action <= next_a.action;
					in_ch.vertex <= next_a.vertex;
					in_ch.row_bits <= next_a.row_bits;
					in_ch.color_in <= next_a.color_in;
					src_gap <= src_idle_on ? 2'($urandom_range(0, 3)) : 2'd0;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_request)
			hold_left <= HOLD_CYCLES;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		glc_result_t want;
		int          pause;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_stall <= '0;
		end else if (out_ch.valid && out_ch.ready) begin
			if (predicted_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected transfer: row %h color %b bad %b",
						out_ch.row_out, out_ch.color_out, out_ch.bad_vertex);
				mismatches++;
			end else begin
				want = predicted_results.pop_front();
				if (out_ch.row_out !== want.row || out_ch.color_out !== want.color ||
					out_ch.bad_vertex !== want.bad) begin
					if (mismatches < 10)
						$display("mismatch: row %h/%h color %b/%b bad %b/%b (exp/act)",
							want.row, out_ch.row_out, want.color, out_ch.color_out,
							want.bad, out_ch.bad_vertex);
					mismatches++;
				end
			end
			pause = rx_idle_on ? $urandom_range(0, 3) : 0;
			rx_stall <= 2'(pause);
			out_ch.ready <= (pause == 0) && (hold_left == 0);
		end else if (rx_stall != 0) begin
			rx_stall <= rx_stall - 2'd1;
			out_ch.ready <= (rx_stall == 2'd1) && (hold_left == 0);
		end else begin
			out_ch.ready <= (hold_left == 0);
		end
	end

	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.action = '0;
		in_ch.vertex = '0;
		in_ch.row_bits = '0;
		in_ch.color_in = 1'b0;
		out_ch.ready = 1'b0;
		hold_request = 1'b0;
		src_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		mismatches = 0;
		vertex_limit = VCOUNT_RESET;
		vertex_colors = '0;
		foreach (graph_rows[i])
			graph_rows[i] = '0;
		phase_counts = '{6'd63, 6'd1, 6'd2, 6'd33, 6'd7, 6'd16,
			6'd31, 6'd32, 6'd0, 6'd20, 6'd5, 6'd32};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full count: extremes, self loop at pivot, alias read
		queue_action(ACT_WRITE, 0, 32'hFFFF_FFFF, 1'b1);
		queue_action(ACT_WRITE, 31, 32'h0, 1'b0);
		queue_action(ACT_WRITE, 5, 32'hAAAA_AAAA, 1'b0);
		queue_action(ACT_WRITE, 1, 32'h8000_0021, 1'b1);
		queue_action(ACT_READ, 0, 32'h0, 1'b0);
		queue_action(ACT_PIVOT, 0, 32'h0, 1'b0);
		queue_action(ACT_READ, 5, 32'h0, 1'b0);
		queue_action(ACT_READ_ALT, 31, 32'hFFFF_FFFF, 1'b1);
		queue_action(ACT_PIVOT, 31, 32'h0, 1'b0);
		queue_action(ACT_PIVOT, 1, 32'h0, 1'b0);
		queue_action(ACT_READ, 1, 32'h0, 1'b0);
		wait_idle();

		// reduced count: bad pivot, access beyond count, neighbors outside count
		write_vertex_count(6'd20);
		@(negedge clk);
		queue_action(ACT_PIVOT, 25, 32'h0, 1'b0);
		queue_action(ACT_WRITE, 25, 32'h1234_5678, 1'b1);
		queue_action(ACT_READ, 25, 32'h0, 1'b0);
		queue_action(ACT_WRITE, 3, 32'hFFFF_0F0F, 1'b0);
		queue_action(ACT_PIVOT, 3, 32'h0, 1'b0);
		queue_action(ACT_READ, 22, 32'h0, 1'b0);
		wait_idle();

		// count zero
		write_vertex_count(6'd0);
		@(negedge clk);
		queue_action(ACT_WRITE, 4, 32'h5, 1'b1);
		queue_action(ACT_PIVOT, 0, 32'h0, 1'b0);
		queue_action(ACT_READ, 31, 32'h0, 1'b0);

		foreach (phase_counts[p]) begin
			wait_idle();
			write_vertex_count(phase_counts[p]);
			src_idle_on = (p % 3) != 0;
			rx_idle_on = (p % 4) != 1;
			if (p == 3) begin
				@(posedge clk);
				hold_request <= 1'b1;
				@(posedge clk);
				hold_request <= 1'b0;
			end
			@(negedge clk);
			repeat (RANDOM_ITEMS / NUM_PHASES)
				pending_actions = {pending_actions, random_action(effective_count())};
		end
		wait_idle();
		repeat (60) @(posedge clk);
		mismatches += predicted_results.size();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
